// ===== hw/rtl/gfba_pkg.sv =====
// Package for the grouped free block allocator.
// Holds the item selector codes and the result status codes.
// No dependencies.
`default_nettype none

package gfba_pkg;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_FILL  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_ORDER    = 2'd2,
    ST_ZERO_BLK = 2'd3
  } status_e;

  localparam int unsigned FieldW = 16;
  localparam int unsigned SpillIdxW = 5;

endpackage

`default_nettype wire

// ===== hw/rtl/gfba_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Used for the free block stack. No dependencies.
`default_nettype none

module gfba_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/grouped_free_block_allocator_top.sv =====
// Grouped free block allocator top level: free block stack, spill and fill sequencer.
// Depends on gfba_pkg and gfba_ram.
`default_nettype none

// An allocate item that reaches the stack does one stack memory read first; any other
// allocate, free or fill item gives a single result, and a free into a full stack gives the
// count word, one spill word per cycle from the single read port of the stack memory, then
// the final result. Results appear one per cycle on res_valid_o and must be taken
// when shown; the receiver cannot stall. A new item may be started in the cycle its
// predecessor's last result is shown.
module grouped_free_block_allocator_top #(
  parameter int unsigned FREE_GROUP_SIZE = 16,
  parameter int unsigned BLOCK_BITS      = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        func_i,
  input  wire logic [gfba_pkg::FieldW-1:0]       block_number_i,
  input  wire logic [gfba_pkg::FieldW-1:0]       fill_word_i,
  output logic                                   res_valid_o,
  output logic [1:0]                             status_o,
  output logic [gfba_pkg::FieldW-1:0]            block_number_res_o,
  output logic                                   need_fill_o,
  output logic [gfba_pkg::SpillIdxW-1:0]         spill_index_o,
  output logic [gfba_pkg::FieldW-1:0]            spill_word_o,
  output logic                                   spill_valid_o,
  output logic                                   last_o
);

  import gfba_pkg::*;

  localparam int unsigned EntryW = (BLOCK_BITS < FieldW) ? BLOCK_BITS : FieldW;
  localparam int unsigned AddrW  = $clog2(FREE_GROUP_SIZE);
  localparam int unsigned CntW   = $clog2(FREE_GROUP_SIZE + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_POP   = 2'd1;
  localparam logic [1:0] S_SPILL = 2'd2;
  localparam logic [1:0] S_PUSH  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              pend_q, pend_d;
  logic [CntW-1:0]   pos_q, pos_d;
  logic [AddrW-1:0]  sidx_q, sidx_d;
  logic [EntryW-1:0] blk_q, blk_d;
  logic [FREE_GROUP_SIZE-1:0] valid_q;
  logic              rvalid_q;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic [AddrW-1:0]  ram_raddr;
  logic [EntryW-1:0] ram_rdata;

  logic [EntryW-1:0] blk_in;
  logic [EntryW-1:0] word_in;
  logic [EntryW-1:0] got;
  logic [AddrW:0]    sidx_next;

  logic                 out_v_d;
  status_e              out_status_d;
  logic [FieldW-1:0]    out_blk_d;
  logic                 out_need_d;
  logic [SpillIdxW-1:0] out_sidx_d;
  logic [FieldW-1:0]    out_sword_d;
  logic                 out_svalid_d;
  logic                 out_last_d;

  assign blk_in    = block_number_i[EntryW-1:0];
  assign word_in   = fill_word_i[EntryW-1:0];
  assign got       = rvalid_q ? ram_rdata : '0;
  assign sidx_next = {1'b0, sidx_q} + 1'b1;
  assign busy      = (state_q != S_IDLE);

  gfba_ram #(
    .Width (EntryW),
    .Depth (FREE_GROUP_SIZE)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    pend_d       = pend_q;
    pos_d        = pos_q;
    sidx_d       = sidx_q;
    blk_d        = blk_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = blk_in;
    ram_raddr    = AddrW'(count_q - 1'b1);
    out_v_d      = 1'b0;
    out_status_d = ST_OK;
    out_blk_d    = '0;
    out_need_d   = 1'b0;
    out_sidx_d   = '0;
    out_sword_d  = '0;
    out_svalid_d = 1'b0;
    out_last_d   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          blk_d   = blk_in;
          out_v_d = 1'b1;
          unique case (func_i)
            FUNC_ALLOC: begin
              if (pend_q) begin
                out_status_d = ST_ORDER;
              end else if (count_q == '0) begin
                out_status_d = ST_NO_SPACE;
              end else begin
                out_v_d = 1'b0;
                state_d = S_POP;
              end
            end
            FUNC_FREE: begin
              if (pend_q) begin
                out_status_d = ST_ORDER;
              end else if (blk_in == '0) begin
                out_status_d = ST_ZERO_BLK;
              end else if (count_q == CntW'(FREE_GROUP_SIZE)) begin
                out_blk_d    = FieldW'(blk_in);
                out_sword_d  = FieldW'(count_q);
                out_svalid_d = 1'b1;
                out_last_d   = 1'b0;
                sidx_d       = '0;
                ram_raddr    = '0;
                state_d      = S_SPILL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AddrW'(count_q);
                count_d   = count_q + 1'b1;
                out_blk_d = FieldW'(blk_in);
              end
            end
            FUNC_FILL: begin
              if (!pend_q) begin
                out_status_d = ST_ORDER;
              end else begin
                if (pos_q == '0) begin
                  count_d = (word_in > EntryW'(FREE_GROUP_SIZE)) ?
                            CntW'(FREE_GROUP_SIZE) : CntW'(word_in);
                end else begin
                  ram_we    = 1'b1;
                  ram_waddr = AddrW'(pos_q - 1'b1);
                  ram_wdata = word_in;
                end
                if (pos_q == CntW'(FREE_GROUP_SIZE)) begin
                  pend_d = 1'b0;
                  pos_d  = '0;
                end else begin
                  pos_d = pos_q + 1'b1;
                end
              end
            end
            default: begin
              out_status_d = ST_ORDER;
            end
          endcase
        end
      end
      S_POP: begin
        out_v_d = 1'b1;
        state_d = S_IDLE;
        if (got == '0) begin
          out_status_d = ST_NO_SPACE;
        end else begin
          count_d   = count_q - 1'b1;
          out_blk_d = FieldW'(got);
          if (count_q == CntW'(1)) begin
            pend_d     = 1'b1;
            pos_d      = '0;
            out_need_d = 1'b1;
          end
        end
      end
      S_SPILL: begin
        out_v_d      = 1'b1;
        out_blk_d    = FieldW'(blk_q);
        out_sidx_d   = SpillIdxW'(sidx_next);
        out_sword_d  = FieldW'(got);
        out_svalid_d = 1'b1;
        out_last_d   = 1'b0;
        if (sidx_q == AddrW'(FREE_GROUP_SIZE - 1)) begin
          ram_raddr = '0;
          state_d   = S_PUSH;
        end else begin
          ram_raddr = AddrW'(sidx_next);
          sidx_d    = AddrW'(sidx_next);
        end
      end
      S_PUSH: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = blk_q;
        count_d   = CntW'(1);
        out_v_d   = 1'b1;
        out_blk_d = FieldW'(blk_q);
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CntW'(1);
      pend_q      <= 1'b0;
      pos_q       <= '0;
      sidx_q      <= '0;
      valid_q     <= '0;
      rvalid_q    <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      pos_q       <= pos_d;
      sidx_q      <= sidx_d;
      rvalid_q    <= valid_q[ram_raddr];
      res_valid_o <= out_v_d;
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q              <= blk_d;
    status_o           <= out_status_d;
    block_number_res_o <= out_blk_d;
    need_fill_o        <= out_need_d;
    spill_index_o      <= out_sidx_d;
    spill_word_o       <= out_sword_d;
    spill_valid_o      <= out_svalid_d;
    last_o             <= out_last_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(FREE_GROUP_SIZE))
    else $error("stack count above group size");

  a_fill_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && (pos_q == '0) |-> count_q == '0)
    else $error("fill pending with non-empty stack");

  a_non_last_spill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_o |-> spill_valid_o)
    else $error("non-final beat without spill word");

  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |=> res_valid_o && last_o)
    else $error("pop did not produce a final beat");

  a_push_follows_spill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUSH |-> $past(state_q) == S_SPILL)
    else $error("push entered without spill");

endmodule

`default_nettype wire

// ===== verif/grouped_free_block_allocator_top_tb.sv =====
// Self-checking testbench for grouped_free_block_allocator_top: directed and random
// alloc, free, fill and unused-selector beats checked against an in-bench free-list predictor.
// Depends on gfba_pkg and the allocator RTL.
module grouped_free_block_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gfba_pkg::*;

  localparam int unsigned Group = 16;
  localparam logic [1:0] FuncUnused = 2'd3;
  localparam int unsigned IdleLimit = 1000;
  localparam int unsigned RandomItems = 186;

  typedef struct {
    logic [1:0]  func;
    logic [15:0] blk;
    logic [15:0] word;
    int unsigned gap;
    bit          drain;
  } pend_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] blk;
    logic        need;
    logic [4:0]  sidx;
    logic [15:0] sword;
    logic        svalid;
    logic        last;
  } result_beat_t;

  typedef struct {
    logic [15:0] stack [Group];
    logic [4:0]  count;
    logic        pending;
    logic [4:0]  pos;
  } free_list_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  func_i = '0;
  logic [15:0] block_number_i = '0;
  logic [15:0] fill_word_i = '0;
  logic        busy;
  logic        res_valid_o;
  logic [1:0]  status_o;
  logic [15:0] block_number_res_o;
  logic        need_fill_o;
  logic [4:0]  spill_index_o;
  logic [15:0] spill_word_o;
  logic        spill_valid_o;
  logic        last_o;

  grouped_free_block_allocator_top #(
    .FREE_GROUP_SIZE(Group),
    .BLOCK_BITS     (16)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .func_i            (func_i),
    .block_number_i    (block_number_i),
    .fill_word_i       (fill_word_i),
    .res_valid_o       (res_valid_o),
    .status_o          (status_o),
    .block_number_res_o(block_number_res_o),
    .need_fill_o       (need_fill_o),
    .spill_index_o     (spill_index_o),
    .spill_word_o      (spill_word_o),
    .spill_valid_o     (spill_valid_o),
    .last_o            (last_o)
  );

  pend_item_t   pend_q[$];
  result_beat_t alloc_results_q[$];
  result_beat_t gen_beats[$];
  free_list_t   dut_list;
  free_list_t   gen_list;
  int unsigned  outstanding = 0;
  int unsigned  items_taken = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  mismatches = 0;
  bit           quiet_stretch = 1'b0;
  bit           drain_next = 1'b0;

  initial forever #1 clk_i = ~clk_i;

  function automatic free_list_t fresh_list();
    free_list_t m;
    foreach (m.stack[i]) m.stack[i] = '0;
    m.count = 5'd1;
    m.pending = 1'b0;
    m.pos = '0;
    return m;
  endfunction

  function automatic void add_beat(ref result_beat_t q[$], input logic [1:0] st,
                                   input logic [15:0] b, input logic need,
                                   input logic [4:0] si, input logic [15:0] sw,
                                   input logic sv, input logic lst);
    result_beat_t r;
    r = '{st, b, need, si, sw, sv, lst};
    q.push_back(r);
  endfunction

  function automatic void predict_free_list(ref free_list_t m, input logic [1:0] f,
                                            input logic [15:0] b, input logic [15:0] w,
                                            ref result_beat_t q[$]);
    logic [15:0] got;
    case (f)
      FUNC_ALLOC: begin
        if (m.pending) begin
          add_beat(q, ST_ORDER, '0, 1'b0, '0, '0, 1'b0, 1'b1);
        end else if (m.count == 0 || m.count > Group) begin
          add_beat(q, ST_NO_SPACE, '0, 1'b0, '0, '0, 1'b0, 1'b1);
        end else begin
          got = m.stack[m.count - 1];
          if (got == 0) begin
            add_beat(q, ST_NO_SPACE, '0, 1'b0, '0, '0, 1'b0, 1'b1);
          end else begin
            m.count = m.count - 1;
            if (m.count == 0) begin
              m.pending = 1'b1;
              m.pos = '0;
              add_beat(q, ST_OK, got, 1'b1, '0, '0, 1'b0, 1'b1);
            end else begin
              add_beat(q, ST_OK, got, 1'b0, '0, '0, 1'b0, 1'b1);
            end
          end
        end
      end
      FUNC_FREE: begin
        if (m.pending) begin
          add_beat(q, ST_ORDER, '0, 1'b0, '0, '0, 1'b0, 1'b1);
        end else if (b == 0) begin
          add_beat(q, ST_ZERO_BLK, '0, 1'b0, '0, '0, 1'b0, 1'b1);
        end else begin
          if (m.count >= Group) begin
            add_beat(q, ST_OK, b, 1'b0, '0, {11'd0, m.count}, 1'b1, 1'b0);
            for (int i = 0; i < Group; i++)
              add_beat(q, ST_OK, b, 1'b0, 5'(i + 1), m.stack[i], 1'b1, 1'b0);
            m.count = '0;
          end
          m.stack[m.count] = b;
          m.count = m.count + 1;
          add_beat(q, ST_OK, b, 1'b0, '0, '0, 1'b0, 1'b1);
        end
      end
      FUNC_FILL: begin
        if (!m.pending) begin
          add_beat(q, ST_ORDER, '0, 1'b0, '0, '0, 1'b0, 1'b1);
        end else begin
          if (m.pos == 0) m.count = (w > Group) ? 5'(Group) : w[4:0];
          else if (m.pos <= Group) m.stack[m.pos - 1] = w;
          m.pos = m.pos + 1;
          if (m.pos > Group) begin
            m.pending = 1'b0;
            m.pos = '0;
          end
          add_beat(q, ST_OK, '0, 1'b0, '0, '0, 1'b0, 1'b1);
        end
      end
      default: add_beat(q, ST_ORDER, '0, 1'b0, '0, '0, 1'b0, 1'b1);
    endcase
  endfunction

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [15:0] rand_blk();
    case ($urandom_range(0, 19))
      0: return 16'h0001;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [15:0] count_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'(Group);
      2: return 16'hFFFF;
      3: return 16'($urandom_range(Group + 1, 65535));
      default: return 16'($urandom_range(1, Group - 1));
    endcase
  endfunction

  function automatic logic [15:0] entry_word(bit bottom);
    if (bottom && $urandom_range(0, 2) == 0) return 16'h0000;
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic queue_item(input logic [1:0] f, input logic [15:0] b, input logic [15:0] w);
    pend_item_t it;
    it.func = f;
    it.blk = b;
    it.word = w;
    it.gap = pick_gap(quiet_stretch);
    it.drain = drain_next;
    drain_next = 1'b0;
    predict_free_list(gen_list, f, b, w, gen_beats);
    gen_beats.delete();
    pend_q.push_back(it);
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // driver
  pend_item_t  staged_item;
  bit          staged = 1'b0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni && !(start && busy)) begin
      if (!staged && pend_q.size() > 0) begin
        staged_item = pend_q.pop_front();
        staged = 1'b1;
        gap_left = staged_item.gap;
      end
      if (staged && gap_left == 0 &&
          (!staged_item.drain || (!start && !busy && outstanding == 0))) begin
        start <= 1'b1;
        func_i <= staged_item.func;
        block_number_i <= staged_item.blk;
        fill_word_i <= staged_item.word;
        staged = 1'b0;
      end else begin
        start <= 1'b0;
        if (staged && gap_left > 0) gap_left--;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : monitor
    result_beat_t want;
    bit took;
    took = rst_ni && start && !busy;
    if (took) predict_free_list(dut_list, func_i, block_number_i, fill_word_i, alloc_results_q);
    if (res_valid_o) begin
      if (alloc_results_q.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        want = alloc_results_q.pop_front();
        check_field("status", 16'(want.status), 16'(status_o));
        check_field("block_number_res", want.blk, block_number_res_o);
        check_field("need_fill", 16'(want.need), 16'(need_fill_o));
        check_field("spill_index", 16'(want.sidx), 16'(spill_index_o));
        check_field("spill_word", want.sword, spill_word_o);
        check_field("spill_valid", 16'(want.svalid), 16'(spill_valid_o));
        check_field("last", 16'(want.last), 16'(last_o));
      end
    end
    outstanding <= alloc_results_q.size();
    items_taken <= items_taken + int'(took);
    idle_cycles <= (took || res_valid_o) ? 0 : idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned random_cnt;
    int unsigned mode_left;
    int unsigned total;
    int unsigned r;
    bit alloc_heavy;
    random_cnt = 0;
    mode_left = 0;
    alloc_heavy = 1'b0;
    dut_list = fresh_list();
    gen_list = fresh_list();

    queue_item(FUNC_ALLOC, 16'hFFFF, 16'hFFFF);
    queue_item(FUNC_FILL, 16'h0000, 16'hFFFF);
    queue_item(FuncUnused, 16'hFFFF, 16'hFFFF);
    queue_item(FUNC_FREE, 16'h0000, 16'h0000);
    queue_item(FUNC_FREE, 16'hFFFF, 16'h0000);
    for (int i = 1; i <= 14; i++) queue_item(FUNC_FREE, 16'h0001 << i, 16'hFFFF);
    queue_item(FUNC_FREE, 16'h0001, 16'h0000);
    queue_item(FUNC_ALLOC, 16'h0000, 16'h0000);
    queue_item(FUNC_ALLOC, 16'h0000, 16'h0000);
    queue_item(FUNC_FREE, 16'h1234, 16'h0000);
    queue_item(FuncUnused, 16'h0000, 16'h0000);
    drain_next = 1'b1;

    while (random_cnt < RandomItems) begin
      if (mode_left == 0) begin
        alloc_heavy = $urandom_range(0, 1);
        quiet_stretch = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(10, 40);
      end
      mode_left--;
      if ($urandom_range(0, 99) < 3) drain_next = 1'b1;
      r = $urandom_range(0, 99);
      if (gen_list.pending) begin
        if (r < 3) queue_item(FUNC_ALLOC, rand_blk(), 16'($urandom_range(0, 65535)));
        else if (r < 6) queue_item(FUNC_FREE, rand_blk(), 16'($urandom_range(0, 65535)));
        else if (r < 8) queue_item(FuncUnused, rand_blk(), 16'($urandom_range(0, 65535)));
        else if (gen_list.pos == 0)
          queue_item(FUNC_FILL, 16'($urandom_range(0, 65535)), count_word());
        else
          queue_item(FUNC_FILL, 16'($urandom_range(0, 65535)), entry_word(gen_list.pos == 1));
      end else begin
        if (r < 3) queue_item(FUNC_FILL, rand_blk(), 16'($urandom_range(0, 65535)));
        else if (r < 5) queue_item(FuncUnused, rand_blk(), 16'($urandom_range(0, 65535)));
        else if (r < 8) queue_item(FUNC_FREE, 16'h0000, 16'($urandom_range(0, 65535)));
        else if ((alloc_heavy && r < 80) || (!alloc_heavy && r >= 80))
          queue_item(FUNC_ALLOC, rand_blk(), 16'($urandom_range(0, 65535)));
        else
          queue_item(FUNC_FREE, rand_blk(), 16'($urandom_range(0, 65535)));
      end
      random_cnt++;
    end
    total = pend_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (items_taken != total || outstanding != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    @(negedge clk_i);
    if (alloc_results_q.size() != 0) begin
      $error("%0d expected result beats never arrived", alloc_results_q.size());
      mismatches++;
    end
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
